### src/ftlpm_pkg.sv
// shared types and codes of the fixed-stride trie longest-prefix-match engine
// no dependencies
`timescale 1ns / 1ps

package ftlpm_pkg;

	// item kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_LEN   = 2'd1,
		ST_POOL_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK
	} state_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] address_bits;
		logic [5:0]  prefix_length;
		logic [31:0] hop_value;
	} req_t;

	typedef struct packed {
		logic        match_found;
		logic [31:0] match_hop;
		status_t     status;
	} res_t;

endpackage

### src/fixed_stride_trie_lpm.sv
// top level of the fixed-stride multibit trie longest-prefix-match engine
// depends on ftlpm_pkg and ftlpm_ram
`timescale 1ns / 1ps

// Longest-prefix match for IPv4 over a multibit trie of MAX_NODES nodes with
// 2^STRIDE entries each, all kept in one entry ram (valid, next hop, child).
// A command is taken at a clock edge with start high and busy low; kind 0
// inserts prefix/length/hop, kind 1 looks up an address. Every command gives
// exactly one result, shown on result for one cycle with done high; the
// receiver cannot stall it. The walk steps through one trie level at a time,
// bound by the single read of the entry ram per level, and then returns to
// idle. An insert with a bad length (zero, above 32, or not a multiple of
// STRIDE) is answered from idle without a walk. After reset all
// MAX_NODES << STRIDE entries (65536 at the defaults) are swept clear, one
// entry a cycle, with busy held high.

module fixed_stride_trie_lpm #(
	parameter int STRIDE    = 8,
	parameter int MAX_NODES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ftlpm_pkg::req_t   request,
	output logic              done,
	output ftlpm_pkg::res_t   result
);

	localparam int              NODE_W  = $clog2(MAX_NODES);
	localparam int              CNT_W   = $clog2(MAX_NODES + 1);
	localparam int              ADDR_W  = NODE_W + STRIDE;
	localparam int              ENTRY_W = 1 + 32 + NODE_W;
	localparam longint unsigned DEPTH   = longint'(MAX_NODES) << STRIDE;

	typedef struct packed {
		logic              valid;
		logic [31:0]       hop;
		logic [NODE_W-1:0] child;
	} entry_t;

	// lengths that an insert may use
	logic [63:0] len_ok;
	for (genvar g = 0; g < 64; g++) begin : g_len
		assign len_ok[g] = (g != 0) && (g <= 32) && ((g % STRIDE) == 0);
	end

	ftlpm_pkg::state_t state_q, state_d;

	logic [ADDR_W-1:0] clr_q;
	logic              kind_q;
	logic [31:0]       addr_q;     // address, next level's bits at the top
	logic [5:0]        len_q;
	logic [31:0]       hop_q;
	logic [5:0]        bits_q;     // address bits consumed through this level
	logic [ADDR_W-1:0] cur_q;      // entry read for this level
	logic              found_q;
	logic [31:0]       best_q;
	logic [CNT_W-1:0]  nodes_q;
	logic              done_q;
	ftlpm_pkg::res_t   result_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	entry_t            ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t            rd;

	logic              accept;
	logic              bad_len;
	logic              last_level;
	logic              lk_end;
	logic              ins_final;
	logic              ins_full;
	logic              ins_alloc;
	logic              walk_end;
	logic [NODE_W-1:0] next_node;
	logic [6:0]        bits_ext;

	assign rd      = entry_t'(ram_rdata);
	assign accept  = start && (state_q == ftlpm_pkg::S_IDLE);
	assign bad_len = (request.kind == ftlpm_pkg::KIND_INSERT) && !len_ok[request.prefix_length];

	// walk decisions on the entry just read
	always_comb begin
		bits_ext   = {1'b0, bits_q} + 7'(STRIDE);
		last_level = bits_ext > 7'd32;
		lk_end     = last_level || (rd.child == '0);
		ins_final  = (bits_q == len_q);
		ins_full   = !ins_final && (rd.child == '0) && (nodes_q == CNT_W'(MAX_NODES));
		ins_alloc  = !ins_final && (rd.child == '0) && (nodes_q != CNT_W'(MAX_NODES));
		next_node  = ins_alloc ? nodes_q[NODE_W-1:0] : rd.child;
		walk_end   = (kind_q == ftlpm_pkg::KIND_LOOKUP) ? lk_end : (ins_final || ins_full);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ftlpm_pkg::S_CLEAR: begin
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = ftlpm_pkg::S_IDLE;
				end
			end
			ftlpm_pkg::S_IDLE: begin
				if (start && !bad_len) begin
					state_d = ftlpm_pkg::S_WALK;
				end
			end
			ftlpm_pkg::S_WALK: begin
				if (walk_end) begin
					state_d = ftlpm_pkg::S_IDLE;
				end
			end
			default: state_d = ftlpm_pkg::S_CLEAR;
		endcase
	end

	// ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = '0;
		ram_raddr = {next_node, addr_q[31 -: STRIDE]};
		unique case (state_q)
			ftlpm_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ftlpm_pkg::S_IDLE: begin
				// root entry for level zero, read speculatively
				ram_raddr = {NODE_W'(0), request.address_bits[31 -: STRIDE]};
			end
			ftlpm_pkg::S_WALK: begin
				if (kind_q == ftlpm_pkg::KIND_INSERT) begin
					ram_we = ins_final || ins_alloc;
					if (ins_final) begin
						ram_wdata = '{valid: 1'b1, hop: hop_q, child: rd.child};
					end else begin
						ram_wdata = '{valid: rd.valid, hop: rd.hop,
							child: nodes_q[NODE_W-1:0]};
					end
				end
			end
			default: ram_we = 1'b0;
		endcase
	end

	assign busy   = (state_q != ftlpm_pkg::S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	ftlpm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ENTRY_W'(ram_wdata)),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftlpm_pkg::S_CLEAR;
			clr_q   <= '0;
			nodes_q <= CNT_W'(1);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == ftlpm_pkg::S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (accept && bad_len) begin
				done_q <= 1'b1;
			end
			if (state_q == ftlpm_pkg::S_WALK) begin
				if (kind_q == ftlpm_pkg::KIND_INSERT && ins_alloc) begin
					nodes_q <= nodes_q + CNT_W'(1);
				end
				if (walk_end) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// walk payload and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= request.kind;
			addr_q   <= request.address_bits << STRIDE;
			len_q    <= request.prefix_length;
			hop_q    <= request.hop_value;
			bits_q   <= 6'(STRIDE);
			cur_q    <= ram_raddr;
			found_q  <= 1'b0;
			best_q   <= '0;
			result_q <= '{match_found: 1'b0, match_hop: 32'd0, status: ftlpm_pkg::ST_BAD_LEN};
		end
		if (state_q == ftlpm_pkg::S_WALK) begin
			if (rd.valid) begin
				found_q <= 1'b1;
				best_q  <= rd.hop;
			end
			if (!walk_end) begin
				addr_q <= addr_q << STRIDE;
				bits_q <= bits_ext[5:0];
				cur_q  <= ram_raddr;
			end else if (kind_q == ftlpm_pkg::KIND_LOOKUP) begin
				result_q <= '{match_found: found_q || rd.valid,
					match_hop: rd.valid ? rd.hop : best_q, status: ftlpm_pkg::ST_OK};
			end else begin
				result_q <= '{match_found: 1'b0, match_hop: 32'd0,
					status: ins_full ? ftlpm_pkg::ST_POOL_FULL : ftlpm_pkg::ST_OK};
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_done_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ftlpm_pkg::S_CLEAR |-> !done_q)
		else $error("result strobe during clearing sweep");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_q <= CNT_W'(MAX_NODES) && nodes_q != '0)
		else $error("node counter out of range");

	a_pool_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ftlpm_pkg::S_WALK |=> nodes_q >= $past(nodes_q))
		else $error("node counter went backward");

	a_lookup_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ftlpm_pkg::S_WALK && ram_we) |-> kind_q == ftlpm_pkg::KIND_INSERT)
		else $error("lookup wrote the entry ram");

	a_match_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.match_found) |-> result_q.status == ftlpm_pkg::ST_OK)
		else $error("match reported with error status");
`endif

endmodule

### src/ftlpm_ram.sv
// generic single-clock ram, one write port and one read port, registered read
// no dependencies
`timescale 1ns / 1ps

module ftlpm_ram #(
	parameter int              WIDTH = 41,
	parameter longint unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
